/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while rst_n is low.
`define RCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication built on the check above.
`define RCE_ASSERT_NEXT(label, cond, prop, msg) \
  `RCE_ASSERT(label, (cond) |=> (prop), msg)

`endif

/* rtl/rce_pkg.sv */
package rce_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int CHANNELS  = 2;
  localparam int CH_W      = 1;
  localparam int LA_MAX    = 1024;
  localparam int PTR_W     = 10;
  localparam int LEN_W     = 11;
  localparam int DL_DEPTH  = CHANNELS * LA_MAX;
  localparam int DL_AW     = CH_W + PTR_W;
  localparam int GAIN_W    = 17;
  localparam int MS_W      = 32;
  localparam int ST_W      = MS_W + GAIN_W;
  localparam int CFG_AW    = 5;

  localparam logic [GAIN_W-1:0] UNITY = 17'd65536;
  localparam logic [17:0] DB_PER_LOG2     = 18'd197283;
  localparam logic [13:0] LOG2_10_OVER_20 = 14'd10885;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_COMP = 2'd1;
  localparam logic [1:0] MODE_EXP  = 2'd2;

  typedef enum logic [2:0] {
    REG_MODE, REG_THRESHOLD, REG_SLOPE, REG_AVG, REG_ATTACK, REG_RELEASE, REG_LOOKAHEAD
  } reg_idx_t;

  typedef logic [15:0][31:0] fac_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bitv;
    v = v_in;
    r = '0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // factor i is 2^-(2^-(i+1)) in Q0.32
  function automatic fac_tab_t gen_exp_factors();
    fac_tab_t t;
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int i = 0; i < 16; i++) begin
      r = isqrt64(r << 32);
      t[i] = r[31:0];
    end
    return t;
  endfunction

  localparam fac_tab_t EXP_FACTOR = gen_exp_factors();

endpackage

/* rtl/rce_ifs.sv */
interface rce_in_if import rce_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       channel;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       frame_last;

  modport source (output valid, channel, sample_in, frame_last, input ready);
  modport sink (input valid, channel, sample_in, frame_last, output ready);
endinterface

interface rce_out_if import rce_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       out_channel;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [GAIN_W-1:0]          gain_now;
  logic                       out_last;

  modport source (output valid, out_channel, sample_out, gain_now, out_last, input ready);
  modport sink (input valid, out_channel, sample_out, gain_now, out_last, output ready);
endinterface

/* rtl/rms_compressor_expander_unit.sv */
// Two-channel RMS compressor/expander with lookahead delay. One sample beat in gives one beat
// out, and one sample is worked on at a time by a sequencer around a single shared multiplier.
// A beat skips the level check when the mode is neither comp nor exp or the mean square is
// zero; otherwise it goes through normalization and 16 squarings for log2, and, when the
// level attenuates, 16 steps for exp2. A result that waits on out_bus.ready holds the next
// input off for as long as it waits. The delay line and the per-channel mean square / gain
// sit in RAMs; after reset a clearing pass zeroes the delay line and mean squares and sets
// the gains to unity, with in_bus.ready low, while register writes are taken as usual.
module rms_compressor_expander_unit import rce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rce_in_if.sink            in_bus,
  rce_out_if.source         out_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_MS, S_NORM, S_LOG, S_LVL, S_ACT, S_ATT, S_E, S_EXP, S_TGT, S_GAIN,
    S_MUL, S_OUT
  } state_t;

  // registers
  logic [1:0]        mode_r;
  logic [15:0]       thr_r;
  logic [16:0]       slope_r;
  logic [15:0]       avg_r;
  logic [15:0]       attack_r;
  logic [15:0]       release_r;
  logic [LEN_W-1:0]  la_r;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NONE;
      thr_r     <= 16'hCE00;
      slope_r   <= 17'd2048;
      avg_r     <= 16'd655;
      attack_r  <= 16'd1966;
      release_r <= 16'd197;
      la_r      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_MODE:      mode_r    <= pwdata[1:0];
        REG_THRESHOLD: thr_r     <= pwdata[15:0];
        REG_SLOPE:     slope_r   <= pwdata[16:0];
        REG_AVG:       avg_r     <= pwdata[15:0];
        REG_ATTACK:    attack_r  <= pwdata[15:0];
        REG_RELEASE:   release_r <= pwdata[15:0];
        REG_LOOKAHEAD: la_r      <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:      prdata = {30'd0, mode_r};
      REG_THRESHOLD: prdata = {16'd0, thr_r};
      REG_SLOPE:     prdata = {15'd0, slope_r};
      REG_AVG:       prdata = {16'd0, avg_r};
      REG_ATTACK:    prdata = {16'd0, attack_r};
      REG_RELEASE:   prdata = {16'd0, release_r};
      REG_LOOKAHEAD: prdata = {21'd0, la_r};
      default:       prdata = '0;
    endcase
  end

  // sequencer state and datapath
  state_t              state_r;
  logic [LEN_W:0]      clr_cnt_r;
  logic                clr_done;
  logic [SAMPLE_W-1:0] x_r;
  logic                chin_r;
  logic                last_r;
  logic [CH_W-1:0]     ch_r;
  logic [MS_W-1:0]     sq_r;
  logic [MS_W-1:0]     ms_r;
  logic [GAIN_W-1:0]   g_r;
  logic [GAIN_W-1:0]   tgt_r;
  logic [SAMPLE_W-1:0] mag_r;
  logic                neg_r;
  logic [31:0]         norm_r;
  logic [4:0]          lz_r;
  logic [31:0]         y_r;
  logic [15:0]         frac_r;
  logic [3:0]          it_r;
  logic [15:0]         lv_r;
  logic [16:0]         as_r;
  logic [16:0]         ad_r;
  logic [22:0]         att_r;
  logic [13:0]         n_r;
  logic [15:0]         f_r;
  logic [32:0]         p_r;
  logic [PTR_W-1:0]    ptr_r [CHANNELS];
  logic                out_valid_r;
  logic                out_chan_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [GAIN_W-1:0]   out_gain_r;
  logic                out_last_r;
  logic [SAMPLE_W-1:0] res_r;

  assign clr_done = clr_cnt_r[LEN_W];

  // memories
  logic              st_we;
  logic [CH_W-1:0]   st_waddr;
  logic [ST_W-1:0]   st_wdata;
  logic [ST_W-1:0]   st_q;
  logic              dl_we;
  logic [DL_AW-1:0]  dl_waddr;
  logic [SAMPLE_W-1:0] dl_wdata;
  logic [DL_AW-1:0]  dl_raddr;
  logic [SAMPLE_W-1:0] dl_q;

  rce_ram #(.WIDTH(ST_W), .DEPTH(CHANNELS)) u_state_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(ch_r), .rdata(st_q)
  );

  rce_ram #(.WIDTH(SAMPLE_W), .DEPTH(DL_DEPTH)) u_delay_ram (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata), .raddr(dl_raddr), .rdata(dl_q)
  );

  // delay pointer handling
  logic [LEN_W-1:0] len;
  logic [PTR_W-1:0] p_eff;
  logic [PTR_W:0]   p_inc;
  logic [PTR_W-1:0] p_next;

  assign len    = (la_r > LEN_W'(LA_MAX)) ? LEN_W'(LA_MAX) : la_r;
  assign p_eff  = ({1'b0, ptr_r[ch_r]} >= len) ? '0 : ptr_r[ch_r];
  assign p_inc  = {1'b0, p_eff} + 1'b1;
  assign p_next = (p_inc >= len) ? '0 : p_inc[PTR_W-1:0];
  assign dl_raddr = {ch_r, p_eff};

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;

  logic [SAMPLE_W-1:0] ux;
  logic [MS_W-1:0]     ms_old;
  logic                ms_up;
  logic [MS_W-1:0]     ms_d;
  logic [48:0]         step_sum;
  logic [32:0]         step_delta;
  logic [MS_W-1:0]     ms_new;
  logic [33:0]         yy;
  logic [21:0]         nl;
  logic [39:0]         lv_sum;
  logic signed [17:0]  thr_s;
  logic signed [17:0]  lvl_s;
  logic signed [17:0]  diff_s;
  logic signed [17:0]  slp_s;
  logic signed [17:0]  nslp_s;
  logic [16:0]         ad;
  logic [16:0]         as_v;
  logic                act;
  logic [34:0]         att_sum;
  logic [37:0]         e_sum;
  logic [63:0]         tg_sum;
  logic [63:0]         tg_shift;
  logic                g_falls;
  logic [15:0]         g_coeff;
  logic [GAIN_W-1:0]   g_d;
  logic [GAIN_W-1:0]   g_new;
  logic [40:0]         r_sum;
  logic [24:0]         r_mag;
  logic [SAMPLE_W-1:0] r_sat;
  logic [SAMPLE_W-1:0] delayed;

  assign ux       = x_r[SAMPLE_W-1] ? (~x_r + 1'b1) : x_r;
  assign ms_old   = st_q[ST_W-1:GAIN_W];
  assign ms_up    = sq_r >= ms_old;
  assign ms_d     = ms_up ? (sq_r - ms_old) : (ms_old - sq_r);
  assign g_falls  = tgt_r < g_r;
  assign g_coeff  = g_falls ? attack_r : release_r;
  assign g_d      = g_falls ? (g_r - tgt_r) : (tgt_r - g_r);
  assign nl       = {6'(lz_r) + 6'd1, 16'd0} - {6'd0, frac_r};

  always_comb begin
    unique case (state_r)
      S_SQ:    begin mul_a = 33'(ux);    mul_b = 32'(ux);              end
      S_MS:    begin mul_a = 33'(ms_d);  mul_b = 32'(avg_r);           end
      S_LOG:   begin mul_a = 33'(y_r);   mul_b = y_r;                  end
      S_LVL:   begin mul_a = 33'(nl);    mul_b = 32'(DB_PER_LOG2);     end
      S_ATT:   begin mul_a = 33'(as_r);  mul_b = 32'(ad_r);            end
      S_E:     begin mul_a = 33'(att_r); mul_b = 32'(LOG2_10_OVER_20); end
      S_EXP:   begin mul_a = p_r;        mul_b = EXP_FACTOR[it_r];     end
      S_GAIN:  begin mul_a = 33'(g_d);   mul_b = 32'(g_coeff);         end
      S_MUL:   begin mul_a = 33'(mag_r); mul_b = 32'(g_r);             end
      default: begin mul_a = '0;         mul_b = '0;                   end
    endcase
  end

  assign prod = {32'd0, mul_a} * {33'd0, mul_b};

  // step toward target, rounding the step up
  assign step_sum   = prod[48:0] + 49'd65535;
  assign step_delta = step_sum[48:16];
  assign ms_new     = ms_up ? (ms_old + step_delta[31:0]) : (ms_old - step_delta[31:0]);
  assign g_new      = g_falls ? (g_r - step_delta[GAIN_W-1:0]) : (g_r + step_delta[GAIN_W-1:0]);

  assign yy     = prod[63:30];
  assign lv_sum = prod[39:0] + 40'h80_0000;

  always_comb begin
    thr_s  = {{2{thr_r[15]}}, thr_r};
    lvl_s  = -$signed({2'b00, lv_r});
    diff_s = thr_s - lvl_s;
    ad     = diff_s[17] ? 17'(-diff_s) : 17'(diff_s);
    slp_s  = {slope_r[16], slope_r};
    nslp_s = -slp_s;
    if (mode_r == MODE_COMP) begin
      act = lvl_s > thr_s;
      if (slp_s < 0) begin
        as_v = '0;
      end else if (slp_s > 18'sd4096) begin
        as_v = 17'd4096;
      end else begin
        as_v = slp_s[16:0];
      end
    end else begin
      act = lvl_s < thr_s;
      as_v = (slp_s > 0) ? '0 : nslp_s[16:0];
    end
  end

  assign att_sum  = prod[34:0] + 35'd2048;
  assign e_sum    = prod[37:0] + 38'd128;
  assign tg_sum   = {31'd0, p_r} + (64'd1 << (6'd15 + n_r[5:0]));
  assign tg_shift = tg_sum >> (6'd16 + n_r[5:0]);

  assign delayed = (len == '0) ? x_r : dl_q;
  assign r_sum   = prod[40:0] + 41'd32768;
  assign r_mag   = r_sum[40:16];

  always_comb begin
    if (neg_r) begin
      r_sat = (r_mag > 25'h80_0000) ? 24'h80_0000 : (~r_mag[SAMPLE_W-1:0] + 1'b1);
    end else begin
      r_sat = (r_mag > 25'h7F_FFFF) ? 24'h7F_FFFF : r_mag[SAMPLE_W-1:0];
    end
  end

  // memory write ports, clearing pass first
  always_comb begin
    st_we    = 1'b0;
    st_waddr = ch_r;
    st_wdata = {ms_r, g_new};
    dl_we    = 1'b0;
    dl_waddr = {ch_r, p_eff};
    dl_wdata = x_r;
    if (!clr_done) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt_r[CH_W-1:0];
      st_wdata = {{MS_W{1'b0}}, UNITY};
      dl_we    = 1'b1;
      dl_waddr = clr_cnt_r[DL_AW-1:0];
      dl_wdata = '0;
    end else if (state_r == S_GAIN) begin
      st_we = 1'b1;
    end else if (state_r == S_MS && len != '0) begin
      dl_we = 1'b1;
    end
  end

  assign in_bus.ready = (state_r == S_IDLE) && clr_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_r[c] <= '0;
      end
    end else begin
      if (!clr_done) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == S_OUT && (!out_valid_r || out_bus.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_bus.valid && clr_done) begin
            x_r    <= in_bus.sample_in;
            chin_r <= in_bus.channel;
            ch_r   <= in_bus.channel;
            last_r <= in_bus.frame_last;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r    <= (prod[47:46] != 2'b00) ? '1 : prod[45:14];
          state_r <= S_MS;
        end
        S_MS: begin
          ms_r  <= ms_new;
          g_r   <= st_q[GAIN_W-1:0];
          neg_r <= delayed[SAMPLE_W-1];
          mag_r <= delayed[SAMPLE_W-1] ? (~delayed + 1'b1) : delayed;
          if (len != '0) begin
            ptr_r[ch_r] <= p_next;
          end
          if ((mode_r == MODE_COMP || mode_r == MODE_EXP) && ms_new != '0) begin
            norm_r  <= ms_new;
            lz_r    <= '0;
            state_r <= S_NORM;
          end else begin
            tgt_r   <= UNITY;
            state_r <= S_GAIN;
          end
        end
        S_NORM: begin
          // byte steps while the top byte is empty, then single bits
          if (norm_r[31:24] == 8'd0) begin
            norm_r <= norm_r << 8;
            lz_r   <= lz_r + 5'd8;
          end else if (!norm_r[31]) begin
            norm_r <= norm_r << 1;
            lz_r   <= lz_r + 5'd1;
          end else begin
            y_r     <= {1'b0, norm_r[31:1]};
            frac_r  <= '0;
            it_r    <= '0;
            state_r <= S_LOG;
          end
        end
        S_LOG: begin
          frac_r <= {frac_r[14:0], yy[31]};
          y_r    <= yy[31] ? yy[32:1] : yy[31:0];
          it_r   <= it_r + 1'b1;
          if (it_r == 4'd15) begin
            state_r <= S_LVL;
          end
        end
        S_LVL: begin
          lv_r    <= lv_sum[39:24];
          state_r <= S_ACT;
        end
        S_ACT: begin
          as_r <= as_v;
          ad_r <= ad;
          if (act) begin
            state_r <= S_ATT;
          end else begin
            tgt_r   <= UNITY;
            state_r <= S_GAIN;
          end
        end
        S_ATT: begin
          att_r   <= att_sum[34:12];
          state_r <= S_E;
        end
        S_E: begin
          n_r     <= e_sum[37:24];
          f_r     <= e_sum[23:8];
          p_r     <= 33'h1_0000_0000;
          it_r    <= '0;
          state_r <= S_EXP;
        end
        S_EXP: begin
          if (f_r[4'd15 - it_r]) begin
            p_r <= prod[64:32];
          end
          it_r <= it_r + 1'b1;
          if (it_r == 4'd15) begin
            state_r <= S_TGT;
          end
        end
        S_TGT: begin
          tgt_r   <= (n_r >= 14'd48) ? '0 : tg_shift[GAIN_W-1:0];
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          g_r     <= g_new;
          state_r <= S_MUL;
        end
        S_MUL: begin
          res_r   <= r_sat;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_bus.ready) begin
            out_chan_r   <= chin_r;
            out_sample_r <= res_r;
            out_gain_r   <= g_r;
            out_last_r   <= last_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.out_channel = out_chan_r;
  assign out_bus.sample_out  = out_sample_r;
  assign out_bus.gain_now    = out_gain_r;
  assign out_bus.out_last    = out_last_r;

endmodule

/* rtl/rce_ram.sv */
module rce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rce_checker.sv */
`include "assert_macros.svh"

module rce_checker import rce_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] sample_out,
  input logic [GAIN_W-1:0]   gain_now
);

  // one sample in flight: ready drops right after an input beat
  `RCE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")

  `RCE_ASSERT(a_gain_range, !out_valid || gain_now <= UNITY, "gain above unity")

  `RCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out),
                   "stalled output beat changed")

  // a result needs an input beat before it: no result is raised out of an idle, empty state
  `RCE_ASSERT_NEXT(a_no_early_out, !out_valid && in_ready, !out_valid, "result with no input")

endmodule

bind rms_compressor_expander_unit rce_checker u_rce_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_bus.valid),
  .in_ready(in_bus.ready),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .sample_out(out_bus.sample_out),
  .gain_now(out_bus.gain_now)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rce_pkg::*;

  typedef struct {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_beat_t;

  typedef struct {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]          gain;
    logic                       last;
  } result_beat_t;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rce_in_if  in_bus ();
  rce_out_if out_bus ();

  rms_compressor_expander_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus.sink),
    .out_bus (out_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the block's registers and state
  logic [1:0]  cur_mode;
  logic [15:0] cur_thr;
  logic [16:0] cur_slope;
  logic [15:0] cur_avg;
  logic [15:0] cur_attack;
  logic [15:0] cur_release;
  logic [10:0] cur_la;
  logic [31:0] ms_state [CHANNELS];
  logic [16:0] gain_state [CHANNELS];
  logic signed [SAMPLE_W-1:0] la_line [CHANNELS][LA_MAX];
  logic [9:0]  la_ptr [CHANNELS];
  logic [31:0] exp_fac [16];

  sample_beat_t send_q[$];
  result_beat_t pending_outs[$];
  int errors;
  int gap_in;
  int gap_out;
  bit hold_in;
  bit steady;
  int cycles;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] smooth_toward(input logic [63:0] old, input logic [63:0] tgt,
                                                input logic [63:0] c);
    logic [63:0] d;
    if (tgt >= old) begin
      d = tgt - old;
      return old + ((d * c + 65535) >> 16);
    end
    d = old - tgt;
    return old - ((d * c + 65535) >> 16);
  endfunction

  // |log2(m / 2^32)| in Q16.16
  function automatic logic [63:0] log2_mag(input logic [31:0] m);
    int e;
    logic [63:0] y, frac;
    e = 31;
    frac = 0;
    while (!m[e]) e--;
    y = (e == 31) ? {32'd0, m} >> 1 : {32'd0, m} << (30 - e);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        frac = frac | 1;
        y = y >> 1;
      end
    end
    return 64'(32 - e) * 65536 - frac;
  endfunction

  function automatic logic [16:0] gain_from_exp(input logic [63:0] e);
    logic [63:0] n, p;
    n = e >> 16;
    p = 64'd1 << 32;
    for (int i = 1; i <= 16; i++)
      if (e[16 - i]) p = (p * exp_fac[i - 1]) >> 32;
    if (n >= 48) return 0;
    return 17'((p + (64'd1 << (15 + n))) >> (16 + n));
  endfunction

  function automatic result_beat_t compress_sample(input sample_beat_t b);
    result_beat_t res;
    int ch;
    longint x, thr, slp, level, diff, delayed;
    logic [63:0] sq, ms, tgt, g, att, mag, r;
    logic [9:0] p;
    int len;
    bit act;
    ch = b.channel;
    x = b.sample;
    thr = longint'($signed(cur_thr));
    slp = longint'($signed(cur_slope));
    tgt = UNITY;
    sq = 64'(x < 0 ? -x : x);
    sq = (sq * sq) >> (2 * SAMPLE_W - 34);
    if (sq > 64'hFFFFFFFF) sq = 64'hFFFFFFFF;
    ms = smooth_toward(ms_state[ch], sq, cur_avg);
    ms_state[ch] = ms[31:0];
    if ((cur_mode == MODE_COMP || cur_mode == MODE_EXP) && ms != 0) begin
      level = -longint'((log2_mag(ms[31:0]) * DB_PER_LOG2 + (64'd1 << 23)) >> 24);
      if (cur_mode == MODE_COMP) begin
        if (slp < 0) slp = 0;
        if (slp > 4096) slp = 4096;
        act = level > thr;
      end else begin
        if (slp > 0) slp = 0;
        act = level < thr;
      end
      if (act) begin
        diff = thr - level;
        if (diff < 0) diff = -diff;
        if (slp < 0) slp = -slp;
        att = (64'(slp) * 64'(diff) + 2048) >> 12;
        tgt = gain_from_exp((att * LOG2_10_OVER_20 + 128) >> 8);
      end
    end
    g = smooth_toward(gain_state[ch], tgt, tgt < gain_state[ch] ? cur_attack : cur_release);
    gain_state[ch] = g[16:0];
    len = cur_la > LA_MAX ? LA_MAX : cur_la;
    if (len == 0) begin
      delayed = x;
    end else begin
      p = la_ptr[ch];
      if (p >= len) p = 0;
      delayed = la_line[ch][p];
      la_line[ch][p] = b.sample;
      p = (p + 1 >= len) ? 10'd0 : p + 1;
      la_ptr[ch] = p;
    end
    mag = 64'(delayed < 0 ? -delayed : delayed);
    r = (mag * g + 32768) >> 16;
    if (delayed < 0) begin
      if (r > (64'd1 << (SAMPLE_W - 1))) r = 64'd1 << (SAMPLE_W - 1);
      r = -r;
    end else if (r > (64'd1 << (SAMPLE_W - 1)) - 1) begin
      r = (64'd1 << (SAMPLE_W - 1)) - 1;
    end
    res.channel = b.channel;
    res.sample = r[SAMPLE_W-1:0];
    res.gain = g[16:0];
    res.last = b.last;
    return res;
  endfunction

  function automatic int pick_gap();
    if (steady) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 40);
  endfunction

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      gap_in <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        pending_outs.push_back(compress_sample('{in_bus.channel, in_bus.sample_in,
                                                 in_bus.frame_last}));
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_in > 0) begin
          gap_in <= gap_in - 1;
          in_bus.valid <= 1'b0;
        end else if (send_q.size() > 0 && !hold_in) begin
          in_bus.valid      <= 1'b1;
          in_bus.channel    <= send_q[0].channel;
          in_bus.sample_in  <= send_q[0].sample;
          in_bus.frame_last <= send_q[0].last;
          void'(send_q.pop_front());
          gap_in <= pick_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      gap_out <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_outs.size() == 0) begin
          $display("%t: unexpected beat ch=%0d sample=%0d gain=%0d", $realtime,
                   out_bus.out_channel, out_bus.sample_out, out_bus.gain_now);
          errors++;
        end else begin
          if (out_bus.out_channel !== pending_outs[0].channel) begin
            $display("%t: out_channel expected %0d actual %0d", $realtime,
                     pending_outs[0].channel, out_bus.out_channel);
            errors++;
          end
          if (out_bus.sample_out !== pending_outs[0].sample) begin
            $display("%t: sample_out expected %0d actual %0d", $realtime,
                     pending_outs[0].sample, out_bus.sample_out);
            errors++;
          end
          if (out_bus.gain_now !== pending_outs[0].gain) begin
            $display("%t: gain_now expected %0d actual %0d", $realtime,
                     pending_outs[0].gain, out_bus.gain_now);
            errors++;
          end
          if (out_bus.out_last !== pending_outs[0].last) begin
            $display("%t: out_last expected %0d actual %0d", $realtime,
                     pending_outs[0].last, out_bus.out_last);
            errors++;
          end
          void'(pending_outs.pop_front());
        end
      end
      if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        gap_out <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(int'(idx) * 4);
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE:      cur_mode    = 2'(value);
      REG_THRESHOLD: cur_thr     = 16'(value);
      REG_SLOPE:     cur_slope   = 17'(value);
      REG_AVG:       cur_avg     = 16'(value);
      REG_ATTACK:    cur_attack  = 16'(value);
      REG_RELEASE:   cur_release = 16'(value);
      REG_LOOKAHEAD: cur_la      = 11'(value);
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (send_q.size() == 0 && !in_bus.valid && pending_outs.size() == 0);
    // a beat is one in, one out, so nothing is in flight here; keep a margin anyway
    repeat (80) @(posedge clk);
  endtask

  task automatic add_sample(input logic ch, input int value, input logic last);
    send_q.push_back('{ch, SAMPLE_W'(value), last});
  endtask

  function automatic int rand_sample();
    int v;
    if ($urandom_range(0, 15) == 0) return 0;
    v = int'($signed(24'($urandom)));
    return v >>> $urandom_range(0, 23);
  endfunction

  function automatic int pick(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  task automatic random_config(input int phase);
    int la;
    write_reg(REG_MODE, phase % 4);
    write_reg(REG_THRESHOLD, pick(-24576, 0));
    write_reg(REG_SLOPE, pick(-65536, 4096));
    write_reg(REG_AVG, $urandom_range(0, 3) == 0 ? pick(0, 65535) : $urandom_range(2000, 65535));
    write_reg(REG_ATTACK, pick(0, 65535));
    write_reg(REG_RELEASE, pick(0, 65535));
    case ($urandom_range(0, 7))
      0: la = 0;
      1: la = LA_MAX;
      2: la = 2047;
      3: la = 1;
      default: la = $urandom_range(2, 24);
    endcase
    write_reg(REG_LOOKAHEAD, la);
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    clk = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.channel = 1'b0;
    in_bus.sample_in = '0;
    in_bus.frame_last = 1'b0;
    out_bus.ready = 1'b0;
    errors = 0;
    cycles = 0;
    hold_in = 1'b0;
    steady = 1'b0;
    cur_mode = MODE_NONE;
    cur_thr = 16'hCE00;
    cur_slope = 17'd2048;
    cur_avg = 16'd655;
    cur_attack = 16'd1966;
    cur_release = 16'd197;
    cur_la = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      ms_state[c] = '0;
      gain_state[c] = UNITY;
      la_ptr[c] = '0;
      for (int k = 0; k < LA_MAX; k++) la_line[c][k] = '0;
    end
    begin
      logic [63:0] r;
      r = 64'd1 << 31;
      for (int i = 0; i < 16; i++) begin
        r = int_sqrt(r << 32);
        exp_fac[i] = r[31:0];
      end
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, then loud extremes in each mode
    add_sample(0, 8388607, 0);
    add_sample(1, -8388608, 1);
    add_sample(0, 0, 0);
    drain();
    write_reg(REG_MODE, MODE_COMP);
    write_reg(REG_AVG, 65535);
    write_reg(REG_ATTACK, 65535);
    write_reg(REG_SLOPE, 8000);
    add_sample(0, 8388607, 0);
    add_sample(0, -8388608, 0);
    add_sample(1, 1, 0);
    add_sample(1, -1, 1);
    add_sample(0, 0, 0);
    drain();
    write_reg(REG_MODE, MODE_EXP);
    write_reg(REG_SLOPE, 100);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_LOOKAHEAD, 2);
    add_sample(0, 0, 0);
    add_sample(0, 1000, 0);
    add_sample(1, -8388608, 0);
    add_sample(0, 8388607, 1);
    add_sample(1, 5, 0);
    drain();
    write_reg(REG_MODE, 3);
    write_reg(REG_SLOPE, -65536);
    write_reg(REG_LOOKAHEAD, 2047);
    add_sample(0, 8388607, 0);
    add_sample(1, -8388608, 1);
    add_sample(0, 77, 0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      random_config(ph + $urandom_range(0, 3));
      steady = ($urandom_range(0, 3) == 0);
      n = 210;
      for (int k = 0; k < n; k++)
        add_sample(1'($urandom), rand_sample(), 1'($urandom));
      if (ph == 4) begin
        // hold the sender until everything sent so far has come back
        wait (send_q.size() < n / 2);
        hold_in = 1'b1;
        wait (!in_bus.valid && pending_outs.size() == 0);
        hold_in = 1'b0;
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
